@@ src/morse_key_to_hid_keycode_top_macros.svh @@
// Assertion helpers for the Morse key decoder.
// Both use the clock clk and the asynchronous reset arst_n of the including module.
`ifndef MORSE_KEY_TO_HID_KEYCODE_TOP_MACROS_SVH
`define MORSE_KEY_TO_HID_KEYCODE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MORSE_HID_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("morse_hid: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MORSE_HID_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("morse_hid: next-cycle check failed");

`endif

@@ src/morse_hid_pkg.sv @@
package morse_hid_pkg;

	// Longest character, in symbols.
	localparam int unsigned MaxSymbols = 5;

	localparam logic [7:0] SpaceKey = 8'd44;
	localparam logic [7:0] NoKey    = 8'd0;

	localparam logic [11:0] DotTimingReset = 12'd10;
	localparam logic [14:0] CharGapReset   = 15'(3 * DotTimingReset);
	localparam logic [14:0] WordGapReset   = 15'(7 * DotTimingReset);

	// One job per input item that sends a character: a keycode and an optional space.
	typedef struct packed {
		logic [7:0] keycode;
		logic       add_space;
	} job_t;

	// Report sequence of one job.
	typedef enum logic [1:0] {
		PH_KEY_PRESS,
		PH_KEY_RELEASE,
		PH_SPACE_PRESS,
		PH_SPACE_RELEASE
	} phase_t;

	// Character to HID keycode. The pattern holds the newest symbol in bit 0, 1 = dash.
	function automatic logic [7:0] lookup_key(logic [2:0] count, logic [4:0] pattern,
		logic invalid);
		logic [7:0] key;
		key = NoKey;
		if (invalid) begin
			key = NoKey;
		end else if (count == 3'd0) begin
			key = SpaceKey;
		end else begin
			case ({count, pattern})
				{3'd2, 5'b00001}: key = 8'd4;
				{3'd4, 5'b01000}: key = 8'd5;
				{3'd4, 5'b01010}: key = 8'd6;
				{3'd3, 5'b00100}: key = 8'd7;
				{3'd1, 5'b00000}: key = 8'd8;
				{3'd4, 5'b00010}: key = 8'd9;
				{3'd3, 5'b00110}: key = 8'd10;
				{3'd4, 5'b00000}: key = 8'd11;
				{3'd2, 5'b00000}: key = 8'd12;
				{3'd4, 5'b00111}: key = 8'd13;
				{3'd3, 5'b00101}: key = 8'd14;
				{3'd4, 5'b00100}: key = 8'd15;
				{3'd2, 5'b00011}: key = 8'd16;
				{3'd2, 5'b00010}: key = 8'd17;
				{3'd3, 5'b00111}: key = 8'd18;
				{3'd4, 5'b00110}: key = 8'd19;
				{3'd4, 5'b01101}: key = 8'd20;
				{3'd3, 5'b00010}: key = 8'd21;
				{3'd3, 5'b00000}: key = 8'd22;
				{3'd1, 5'b00001}: key = 8'd23;
				{3'd3, 5'b00001}: key = 8'd24;
				{3'd4, 5'b00001}: key = 8'd25;
				{3'd3, 5'b00011}: key = 8'd26;
				{3'd4, 5'b01001}: key = 8'd27;
				{3'd4, 5'b01011}: key = 8'd28;
				{3'd4, 5'b01100}: key = 8'd29;
				{3'd5, 5'b01111}: key = 8'd30;
				{3'd5, 5'b00111}: key = 8'd31;
				{3'd5, 5'b00011}: key = 8'd32;
				{3'd5, 5'b00001}: key = 8'd33;
				{3'd5, 5'b00000}: key = 8'd34;
				{3'd5, 5'b10000}: key = 8'd35;
				{3'd5, 5'b11000}: key = 8'd36;
				{3'd5, 5'b11100}: key = 8'd37;
				{3'd5, 5'b11110}: key = 8'd38;
				{3'd5, 5'b11111}: key = 8'd39;
				default:          key = NoKey;
			endcase
		end
		return key;
	endfunction

endpackage

@@ src/morse_key_to_hid_keycode_top.sv @@
// A sending sample writes its job into the queue; its reports are then registered at the output.
// Throughput: one sample per cycle while full is low; a sample sending a character
// gives two or four reports: press and release of its key, and optionally of a space.
// The two-slot job queue between the run tracker and the report sequencer sets how far they drift.
// Reset: arst_n clears all run and character state, empties the queue and the output,
// and sets the dot timing to 10 samples.
`include "morse_key_to_hid_keycode_top_macros.svh"

module morse_key_to_hid_keycode_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        key_level,
	input  logic        end_of_buffer,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  keycode,
	output logic        is_press,
	output logic        last_of_run,
	input  logic        cfg_we,
	input  logic [11:0] cfg_wdata
);

	logic                job_push;
	morse_hid_pkg::job_t job;
	logic                q_full;
	logic                head_valid;
	morse_hid_pkg::job_t head;
	logic                rd_en;

	assign full = q_full;

	// Front: run tracking and character classification.
	morse_hid_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.q_full        (q_full),
		.key_level     (key_level),
		.end_of_buffer (end_of_buffer),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.job_push      (job_push),
		.job           (job)
	);

	// Job queue between the two halves.
	morse_hid_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (job_push),
		.wr_job     (job),
		.rd_en      (rd_en),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head)
	);

	// Back: turns each job into its press and release reports.
	morse_hid_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head        (head),
		.rd_en       (rd_en),
		.pop         (pop),
		.empty       (empty),
		.keycode     (keycode),
		.is_press    (is_press),
		.last_of_run (last_of_run)
	);

	// A press report is never the final report of a sample.
	`MORSE_HID_ASSERT_SAME(a_press_not_last, !empty && is_press, !last_of_run)
	// Release reports always carry keycode zero.
	`MORSE_HID_ASSERT_SAME(a_release_zero, !empty && !is_press, keycode == 8'd0)
	// Taking a press report brings its release straight after.
	`MORSE_HID_ASSERT_NEXT(a_release_follows, pop && !empty && is_press, !empty && !is_press)

endmodule

@@ src/morse_hid_front.sv @@
module morse_hid_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  logic                      q_full,
	input  logic                      key_level,
	input  logic                      end_of_buffer,
	input  logic                      cfg_we,
	input  logic [11:0]               cfg_wdata,
	output logic                      job_push,
	output morse_hid_pkg::job_t       job
);

	logic        dot_timing_q_unused;
	logic [11:0] dot_timing_q;
	logic [14:0] char_gap_q;
	logic [14:0] word_gap_q;

	logic        started_q, started_d;
	logic        level_q, level_d;
	logic [15:0] len_q, len_d;
	logic [2:0]  cnt_q, cnt_d;
	logic [4:0]  pat_q, pat_d;
	logic        tl_q, tl_d;

	logic        accept;
	logic        dash;
	logic        gap_send;
	logic        word_send;
	logic        flush;
	logic [7:0]  key_code;

	assign accept = push && !q_full;
	assign dot_timing_q_unused = 1'b0;

	// Timing register and the gap thresholds derived from it on each write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_timing_q <= morse_hid_pkg::DotTimingReset;
			char_gap_q   <= morse_hid_pkg::CharGapReset;
			word_gap_q   <= morse_hid_pkg::WordGapReset;
		end else if (cfg_we) begin
			dot_timing_q <= cfg_wdata;
			char_gap_q   <= {3'b000, cfg_wdata} + {2'b00, cfg_wdata, 1'b0};
			word_gap_q   <= {cfg_wdata, 3'b000} - {3'b000, cfg_wdata};
		end
	end

	// Run tracking and symbol collection for one sample.
	always_comb begin
		started_d = started_q;
		level_d   = level_q;
		len_d     = len_q;
		cnt_d     = cnt_q;
		pat_d     = pat_q;
		tl_d      = tl_q;
		gap_send  = 1'b0;
		word_send = 1'b0;
		dash      = len_q > {4'b0000, dot_timing_q};
		if (!started_q) begin
			started_d = 1'b1;
			level_d   = key_level;
			len_d     = 16'd1;
		end else if (key_level != level_q) begin
			if (level_q) begin
				if (cnt_q >= 3'(morse_hid_pkg::MaxSymbols)) begin
					tl_d = 1'b1;
				end else begin
					pat_d = {pat_q[3:0], dash};
					cnt_d = cnt_q + 3'd1;
				end
			end else if (len_q >= {1'b0, char_gap_q}) begin
				gap_send  = 1'b1;
				word_send = len_q >= {1'b0, word_gap_q};
			end
			level_d = key_level;
			len_d   = 16'd1;
		end else if (len_q != 16'hFFFF) begin
			len_d = len_q + 16'd1;
		end

		// The character is looked up before a gap or the buffer end clears it.
		key_code = morse_hid_pkg::lookup_key(cnt_d, pat_d, tl_d);
		flush    = end_of_buffer && !gap_send && ((cnt_d != 3'd0) || tl_d);

		if (gap_send) begin
			cnt_d = 3'd0;
			pat_d = 5'd0;
			tl_d  = 1'b0;
		end
		if (end_of_buffer) begin
			started_d = 1'b0;
			level_d   = 1'b0;
			len_d     = 16'd1;
			cnt_d     = 3'd0;
			pat_d     = 5'd0;
			tl_d      = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			level_q   <= 1'b0;
			len_q     <= 16'd1;
			cnt_q     <= 3'd0;
			pat_q     <= 5'd0;
			tl_q      <= 1'b0;
		end else if (accept) begin
			started_q <= started_d;
			level_q   <= level_d;
			len_q     <= len_d;
			cnt_q     <= cnt_d;
			pat_q     <= pat_d;
			tl_q      <= tl_d;
		end
	end

	// A job is queued for every accepted sample that sends a character.
	assign job_push      = accept && (gap_send || flush) && !dot_timing_q_unused;
	assign job.keycode   = key_code;
	assign job.add_space = word_send;

endmodule

@@ src/morse_hid_queue.sv @@
module morse_hid_queue (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  morse_hid_pkg::job_t       wr_job,
	input  logic                      rd_en,
	output logic                      full,
	output logic                      head_valid,
	output morse_hid_pkg::job_t       head
);

	// Two slots; slot 0 is always the oldest job.
	morse_hid_pkg::job_t slot0_q;
	morse_hid_pkg::job_t slot1_q;
	logic [1:0]          count_q;

	assign full       = count_q == 2'd2;
	assign head_valid = count_q != 2'd0;
	assign head       = slot0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else if (wr_en && !rd_en) begin
			count_q <= count_q + 2'd1;
		end else if (rd_en && !wr_en) begin
			count_q <= count_q - 2'd1;
		end
	end

	// Payload slots shift towards the head on a read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (count_q == 2'd2) begin
				slot0_q <= slot1_q;
				if (wr_en) begin
					slot1_q <= wr_job;
				end
			end else if (wr_en) begin
				slot0_q <= wr_job;
			end
		end else if (wr_en) begin
			if (count_q == 2'd0) begin
				slot0_q <= wr_job;
			end else begin
				slot1_q <= wr_job;
			end
		end
	end

endmodule

@@ src/morse_hid_back.sv @@
module morse_hid_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      head_valid,
	input  morse_hid_pkg::job_t       head,
	output logic                      rd_en,
	input  logic                      pop,
	output logic                      empty,
	output logic [7:0]                keycode,
	output logic                      is_press,
	output logic                      last_of_run
);

	morse_hid_pkg::phase_t phase_q, phase_d;

	logic       valid_q;
	logic [7:0] keycode_q;
	logic       press_q;
	logic       last_q;

	logic       out_free;
	logic       load;
	logic [7:0] nxt_keycode;
	logic       nxt_press;
	logic       nxt_last;

	// The output register takes a new report when it is empty or being read.
	assign out_free = !valid_q || pop;
	assign load     = out_free && head_valid;

	// Report sequencer: press, release, and optionally a space press and release.
	always_comb begin
		phase_d     = phase_q;
		nxt_keycode = morse_hid_pkg::NoKey;
		nxt_press   = 1'b0;
		nxt_last    = 1'b0;
		rd_en       = 1'b0;
		unique case (phase_q)
			morse_hid_pkg::PH_KEY_PRESS: begin
				nxt_keycode = head.keycode;
				nxt_press   = 1'b1;
				if (load) begin
					phase_d = morse_hid_pkg::PH_KEY_RELEASE;
				end
			end
			morse_hid_pkg::PH_KEY_RELEASE: begin
				nxt_last = !head.add_space;
				if (load) begin
					if (head.add_space) begin
						phase_d = morse_hid_pkg::PH_SPACE_PRESS;
					end else begin
						phase_d = morse_hid_pkg::PH_KEY_PRESS;
						rd_en   = 1'b1;
					end
				end
			end
			morse_hid_pkg::PH_SPACE_PRESS: begin
				nxt_keycode = morse_hid_pkg::SpaceKey;
				nxt_press   = 1'b1;
				if (load) begin
					phase_d = morse_hid_pkg::PH_SPACE_RELEASE;
				end
			end
			morse_hid_pkg::PH_SPACE_RELEASE: begin
				nxt_last = 1'b1;
				if (load) begin
					phase_d = morse_hid_pkg::PH_KEY_PRESS;
					rd_en   = 1'b1;
				end
			end
			default: begin
				phase_d = morse_hid_pkg::PH_KEY_PRESS;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= morse_hid_pkg::PH_KEY_PRESS;
			valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (out_free) begin
				valid_q <= head_valid;
			end
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (load) begin
			keycode_q <= nxt_keycode;
			press_q   <= nxt_press;
			last_q    <= nxt_last;
		end
	end

	assign empty       = !valid_q;
	assign keycode     = keycode_q;
	assign is_press    = press_q;
	assign last_of_run = last_q;

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

	localparam int unsigned CycleLimit    = 100_000;
	localparam int unsigned SettleCycles  = 12;
	localparam int unsigned HoldCycles    = 300;
	localparam int unsigned IdlePercent   = 34;
	localparam int unsigned PrintLimit    = 200;
	localparam int unsigned CharGapDots   = 3;
	localparam int unsigned WordGapDots   = 7;
	localparam logic [15:0] RunLengthMax  = 16'hFFFF;
	localparam logic [7:0]  FirstTableKey = 8'd4;
	localparam logic [11:0] DotTimingMin  = 12'd1;

	typedef struct packed {
		logic [7:0] keycode;
		logic       is_press;
		logic       last_of_run;
	} hid_report_t;

	// Tracks key runs as the decoder should and holds the reports still owed by it.
	class report_checker;
		logic [11:0] dot_timing;
		bit          started;
		bit          run_level;
		logic [15:0] run_length;
		logic [2:0]  symbol_count;
		logic [4:0]  symbol_pattern;
		bit          too_long;
		string       morse_table[36];
		hid_report_t pending_reports[$];
		hid_report_t sample_reports[$];
		int unsigned reports_due;
		int unsigned errors;

		function new();
			// Letters A to Z, then digits 1 to 9 and 0; keycodes follow in the same order.
			morse_table = '{".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
				".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
				"..-", "...-", ".--", "-..-", "-.--", "--..", ".----", "..---", "...--",
				"....-", ".....", "-....", "--...", "---..", "----.", "-----"};
			dot_timing = morse_hid_pkg::DotTimingReset;
			reports_due = 0;
			errors = 0;
			clear_buffer();
		endfunction

		function void clear_character();
			symbol_count = 0;
			symbol_pattern = 0;
			too_long = 0;
		endfunction

		function void clear_buffer();
			started = 0;
			run_level = 0;
			run_length = 1;
			clear_character();
		endfunction

		// Keycode of the character built so far.
		function logic [7:0] character_key();
			logic [4:0] bits;
			if (too_long)
				return morse_hid_pkg::NoKey;
			if (symbol_count == 0)
				return morse_hid_pkg::SpaceKey;
			for (int idx = 0; idx < 36; idx++) begin
				if (morse_table[idx].len() == symbol_count) begin
					bits = 0;
					for (int k = 0; k < morse_table[idx].len(); k++)
						bits = {bits[3:0], morse_table[idx][k] == "-"};
					if (bits == symbol_pattern)
						return FirstTableKey + 8'(idx);
				end
			end
			return morse_hid_pkg::NoKey;
		endfunction

		function void send_character(logic [7:0] key);
			sample_reports.push_back('{keycode: key, is_press: 1'b1, last_of_run: 1'b0});
			sample_reports.push_back('{keycode: morse_hid_pkg::NoKey, is_press: 1'b0,
				last_of_run: 1'b0});
		endfunction

		// Notes one accepted sample and queues the reports that it causes.
		function void note_sample(bit level, bit last);
			hid_report_t r;
			sample_reports.delete();
			if (!started) begin
				started = 1;
				run_level = level;
				run_length = 1;
			end else if (level != run_level) begin
				if (run_level) begin
					// An on-run has ended: add a dot or a dash.
					if (symbol_count >= morse_hid_pkg::MaxSymbols) begin
						too_long = 1;
					end else begin
						symbol_pattern = {symbol_pattern[3:0], run_length > dot_timing};
						symbol_count++;
					end
				end else if (run_length >= dot_timing * CharGapDots) begin
					// An off-run long enough to close the character.
					send_character(character_key());
					if (run_length >= dot_timing * WordGapDots)
						send_character(morse_hid_pkg::SpaceKey);
					clear_character();
				end
				run_level = level;
				run_length = 1;
			end else if (run_length != RunLengthMax) begin
				run_length++;
			end
			if (last) begin
				if (symbol_count != 0 || too_long)
					send_character(character_key());
				clear_buffer();
			end
			foreach (sample_reports[i]) begin
				r = sample_reports[i];
				r.last_of_run = (i == sample_reports.size() - 1);
				pending_reports.push_back(r);
				reports_due++;
			end
		endfunction

		task report(string what);
			errors++;
			if (errors <= PrintLimit)
				$display("mismatch: %s", what);
		endtask

		// Compares one accepted report with the oldest one owed.
		task check_report(logic [7:0] got_key, logic got_press, logic got_last);
			hid_report_t want;
			if (pending_reports.size() == 0) begin
				report($sformatf("unexpected report, keycode %0d press %0b", got_key, got_press));
			end else begin
				want = pending_reports.pop_front();
				if (got_key !== want.keycode)
					report($sformatf("keycode %0d, expected %0d", got_key, want.keycode));
				if (got_press !== want.is_press)
					report($sformatf("is_press %0b, expected %0b", got_press, want.is_press));
				if (got_last !== want.last_of_run)
					report($sformatf("last_of_run %0b, expected %0b", got_last, want.last_of_run));
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        push          = 1'b0;
	logic        full;
	logic        key_level     = 1'b0;
	logic        end_of_buffer = 1'b0;
	logic        empty;
	logic        pop           = 1'b0;
	logic [7:0]  keycode;
	logic        is_press;
	logic        last_of_run;
	logic        cfg_we        = 1'b0;
	logic [11:0] cfg_wdata     = '0;

	report_checker board = new();
	bit            tx_steady    = 1'b0;
	bit            rx_steady    = 1'b0;
	bit            hold_request = 1'b0;
	int unsigned   samples_sent = 0;
	int unsigned   cycle_count  = 0;

	morse_key_to_hid_keycode_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.key_level    (key_level),
		.end_of_buffer(end_of_buffer),
		.empty        (empty),
		.pop          (pop),
		.keycode      (keycode),
		.is_press     (is_press),
		.last_of_run  (last_of_run),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Offers one sample, with random idle cycles first, and waits for its transaction.
	task automatic send_sample(input bit level, input bit last);
		while (!tx_steady && $urandom_range(99) < IdlePercent) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		key_level <= level;
		end_of_buffer <= last;
		do @(posedge clk); while (full);
		board.note_sample(level, last);
		samples_sent++;
	endtask

	task automatic send_run(input bit level, input int unsigned len, input bit last);
		for (int i = 0; i < len; i++)
			send_sample(level, last && (i == len - 1));
	endtask

	// Keys one character; tight runs sit right on the dot, dash and symbol gap limits.
	task automatic key_character(input string syms, input int unsigned gap, input bit tight);
		int unsigned dt;
		int unsigned len;
		dt = board.dot_timing;
		for (int i = 0; i < syms.len(); i++) begin
			if (syms[i] == "-")
				len = tight ? dt + 1 : dt + 1 + $urandom_range(dt);
			else
				len = tight ? dt : 1 + $urandom_range(dt - 1);
			send_run(1'b1, len, 1'b0);
			if (i + 1 < syms.len()) begin
				len = tight ? CharGapDots * dt - 1 : 1 + $urandom_range(CharGapDots * dt - 2);
				send_run(1'b0, len, 1'b0);
			end
		end
		if (gap != 0)
			send_run(1'b0, gap, 1'b0);
	endtask

	// An off-run that is a symbol gap, a character gap or a word gap.
	function automatic int unsigned pick_gap(int unsigned dt);
		case ($urandom_range(2))
			0: return 1 + $urandom_range(CharGapDots * dt - 2);
			1: return CharGapDots * dt + $urandom_range((WordGapDots - CharGapDots) * dt - 1);
			default: return WordGapDots * dt + $urandom_range(3);
		endcase
	endfunction

	// One buffer: mostly well-formed characters, sometimes noise or over-long codes.
	task automatic random_buffer();
		int unsigned dt;
		int unsigned chars;
		int unsigned n;
		string syms;
		dt = board.dot_timing;
		if ($urandom_range(99) < 20) begin
			n = 4 + $urandom_range(8);
			for (int i = 0; i < n; i++)
				send_sample($urandom_range(1), i == n - 1);
		end else begin
			if ($urandom_range(2) == 0)
				send_run(1'b0, pick_gap(dt), 1'b0);
			chars = 1 + $urandom_range(1);
			for (int c = 0; c < chars; c++) begin
				if ($urandom_range(9) < 8) begin
					syms = board.morse_table[$urandom_range(35)];
				end else begin
					syms = "";
					n = 1 + $urandom_range(6);
					for (int i = 0; i < n; i++) begin
						if ($urandom_range(1))
							syms = {syms, "-"};
						else
							syms = {syms, "."};
					end
				end
				key_character(syms, (c + 1 < chars) ? pick_gap(dt) : 0, $urandom_range(3) == 0);
			end
			case ($urandom_range(2))
				0: begin
					send_run(1'b0, pick_gap(dt), 1'b0);
					send_sample(1'b1, 1'b1);
				end
				1: send_sample(1'b0, 1'b1);
				default: send_run(1'b0, pick_gap(dt), 1'b1);
			endcase
		end
	endtask

	// Stops offering samples and waits until every owed report has arrived.
	task automatic drain_reports();
		push <= 1'b0;
		while (board.pending_reports.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_dot_timing(input logic [11:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.dot_timing = value;
	endtask

	// Stimulus.
	initial begin : stimulus
		int unsigned phase_samples;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// One-sample buffers, then a dot right on the reset dot timing of ten samples,
		// flushed by the last sample of the buffer.
		send_sample(1'b1, 1'b1);
		send_sample(1'b0, 1'b1);
		key_character(".", 0, 1'b1);
		send_sample(1'b0, 1'b1);

		// Shortest dot timing, on every boundary; the word gap ends on the last sample.
		drain_reports();
		write_dot_timing(DotTimingMin);
		send_run(1'b1, 1, 1'b0);
		send_run(1'b0, 3, 1'b0);
		send_run(1'b1, 2, 1'b0);
		send_run(1'b0, 2, 1'b0);
		send_run(1'b1, 1, 1'b0);
		send_run(1'b0, 6, 1'b0);
		send_run(1'b1, 2, 1'b0);
		send_run(1'b0, 7, 1'b0);
		send_sample(1'b1, 1'b1);
		// A code of six symbols is too long and gives keycode zero.
		key_character("......", 0, 1'b1);
		send_sample(1'b0, 1'b1);

		// The receiver holds off while a steady stream of characters fills the block.
		drain_reports();
		hold_request = 1'b1;
		tx_steady = 1'b1;
		for (int i = 0; i < 6; i++) begin
			send_run(1'b1, 1, 1'b0);
			send_run(1'b0, CharGapDots, 1'b0);
		end
		send_sample(1'b1, 1'b1);
		tx_steady = 1'b0;

		// Random buffers with no idling on either side.
		drain_reports();
		tx_steady = 1'b1;
		rx_steady = 1'b1;
		phase_samples = samples_sent;
		while (samples_sent - phase_samples < 15)
			random_buffer();
		tx_steady = 1'b0;
		rx_steady = 1'b0;

		drain_reports();
		if (board.errors == 0 && board.pending_reports.size() == 0)
			$display("PASS morse_key_to_hid_keycode_top");
		else
			$display("FAIL morse_key_to_hid_keycode_top");
		$finish;
	end

	// Result side: takes each report transaction and checks it, stalling at random.
	initial begin : receive_reports
		int unsigned hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (pop && !empty)
				board.check_report(keycode, is_press, last_of_run);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HoldCycles;
			end
			if (hold_left != 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= rx_steady || ($urandom_range(99) >= IdlePercent);
			end
		end
	end

	// Timeout.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("FAIL morse_key_to_hid_keycode_top");
			$finish;
		end
	end

endmodule
